// ----- hw/rtl/pe_image_checksum_top_macros.svh -----
// Assertion macros for the PE image checksum block.
// Used by pe_image_checksum_top; no other dependencies.
`ifndef PE_IMAGE_CHECKSUM_TOP_MACROS_SVH
`define PE_IMAGE_CHECKSUM_TOP_MACROS_SVH
`ifndef SYNTHESIS
// antecedent holds -> consequent holds in the same cycle
`define PIC_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define PIC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PIC_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PIC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/pic_pkg.sv -----
// Package for the PE image checksum block: transaction types, constants,
// byte insert helper. No dependencies.
package pic_pkg;

    localparam logic [31:0] HDR_PTR_POS   = 32'h0000_003C;
    localparam logic [31:0] SUM_FIELD_OFS = 32'h0000_0058;

    typedef struct packed {
        logic [15:0] data_word;
        logic [1:0]  byte_count;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] computed_checksum;
        logic [31:0] header_checksum;
    } out_item_t;

    // final state of one image, handed from accumulator to finisher
    typedef struct packed {
        logic [15:0] sum;
        logic [31:0] len;
        logic [31:0] chk;
    } snap_t;

    // finisher status toward the top-level control
    typedef struct packed {
        logic snap_busy;
        logic snap_ready;
    } fin_stat_t;

    // replace byte idx of a 32-bit word
    function automatic logic [31:0] put_byte(logic [31:0] r, logic [1:0] idx,
                                             logic [7:0] b);
        logic [31:0] v;
        v = r;
        unique case (idx)
            2'd0: v[7:0]   = b;
            2'd1: v[15:8]  = b;
            2'd2: v[23:16] = b;
            2'd3: v[31:24] = b;
            default: v = r;
        endcase
        return v;
    endfunction

endpackage

// ----- hw/rtl/pic_accum.sv -----
// Running state of the PE checksum: ones'-complement sum, byte count,
// header offset and stored checksum capture. Depends on pic_pkg.
module pic_accum (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  pic_pkg::in_item_t item,
    output pic_pkg::snap_t   snap
);
    import pic_pkg::*;

    logic [15:0] sum_reg, sum_next;
    logic [31:0] len_reg, len_next;
    logic [31:0] hdr_reg, hdr_next;
    logic [31:0] chk_reg, chk_next;

    logic        has0, has1;
    logic [15:0] word_add;
    logic [16:0] sum_wide;
    logic [31:0] q1;
    logic [31:0] hpos0, hpos1;
    logic [31:0] hdr_a;
    logic [31:0] d0, d1;
    logic [31:0] chk_a;

    always_comb
    begin
        has0 = (item.byte_count != 2'd0);
        has1 = item.byte_count[1];
        word_add = has1 ? item.data_word : {8'h00, item.data_word[7:0]};
        sum_wide = {1'b0, sum_reg} + {1'b0, word_add};
        q1 = len_reg + 32'd1;

        // first byte, position len_reg
        hpos0 = len_reg - HDR_PTR_POS;
        hdr_a = hdr_reg;
        if (has0 && hpos0[31:2] == 30'd0)
            hdr_a = put_byte(hdr_reg, hpos0[1:0], item.data_word[7:0]);
        d0 = len_reg - hdr_a - SUM_FIELD_OFS;
        chk_a = chk_reg;
        if (has0 && d0[31:2] == 30'd0)
            chk_a = put_byte(chk_reg, d0[1:0], item.data_word[7:0]);

        // second byte, position len_reg + 1, sees offset after first byte
        hpos1 = q1 - HDR_PTR_POS;
        hdr_next = hdr_a;
        if (has1 && hpos1[31:2] == 30'd0)
            hdr_next = put_byte(hdr_a, hpos1[1:0], item.data_word[15:8]);
        d1 = q1 - hdr_next - SUM_FIELD_OFS;
        chk_next = chk_a;
        if (has1 && d1[31:2] == 30'd0)
            chk_next = put_byte(chk_a, d1[1:0], item.data_word[15:8]);

        if (has0)
            sum_next = sum_wide[15:0] + {15'd0, sum_wide[16]};
        else
            sum_next = sum_reg;
        len_next = len_reg + {30'd0, has1, has0 & ~has1};

        snap.sum = sum_next;
        snap.len = len_next;
        snap.chk = chk_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            len_reg <= '0;
            hdr_reg <= '0;
            chk_reg <= '0;
        end
        else if (fire)
        begin
            if (item.last)
            begin
                sum_reg <= '0;
                len_reg <= '0;
                hdr_reg <= '0;
                chk_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
                len_reg <= len_next;
                hdr_reg <= hdr_next;
                chk_reg <= chk_next;
            end
        end
    end

endmodule

// ----- hw/rtl/pic_finish.sv -----
// Image finish: holds the final snapshot, removes the stored checksum,
// folds, adds length, and presents the result. Depends on pic_pkg.
module pic_finish (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  pic_pkg::snap_t     snap,
    input  logic               result_ready,
    output logic               result_valid,
    output pic_pkg::out_item_t result,
    output pic_pkg::fin_stat_t stat
);
    import pic_pkg::*;

    logic        snap_valid_reg;
    snap_t       snap_reg;
    logic        out_valid_reg;
    out_item_t   out_reg;
    logic        out_free;
    logic        snap_fire;
    logic [31:0] sum32, sm1, yy;
    logic [16:0] f1;
    logic [16:0] f2;
    out_item_t   res_next;

    assign out_free  = !out_valid_reg || result_ready;
    assign snap_fire = snap_valid_reg && out_free;

    always_comb
    begin
        sum32 = {16'd0, snap_reg.sum};
        sm1   = sum32 - 32'd1;
        // borrow rule of the file format
        if (sm1 < snap_reg.chk)
            yy = sm1 - snap_reg.chk;
        else
            yy = sum32 - snap_reg.chk;
        f1 = {1'b0, yy[15:0]} + {1'b0, yy[31:16]};
        f2 = {1'b0, f1[15:0]} + {16'd0, f1[16]};
        res_next.computed_checksum = {15'd0, f2} + snap_reg.len;
        res_next.header_checksum   = snap_reg.chk;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (load)
                snap_valid_reg <= 1'b1;
            else if (snap_fire)
                snap_valid_reg <= 1'b0;
            if (snap_fire)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            snap_reg <= snap;
        if (snap_fire)
            out_reg <= res_next;
    end

    assign result_valid    = out_valid_reg;
    assign result          = out_reg;
    assign stat.snap_busy  = snap_valid_reg;
    assign stat.snap_ready = !snap_valid_reg || out_free;

endmodule

// ----- hw/rtl/pe_image_checksum_top.sv -----
// PE image checksum, top level: input register and flow control.
// Depends on pic_pkg, pic_accum, pic_finish, pe_image_checksum_top_macros.svh.
//
// Usage:
//   item channel  : item_valid / item_ready / item (data_word, byte_count, last).
//                   Words are little-endian image bytes; byte_count 1 marks a
//                   single valid low byte. last closes the image.
//   result channel: result_valid / result_ready / result (computed_checksum,
//                   header_checksum). One transaction per image, none for
//                   items without last.
//   Throughput    : one item per cycle while no last item stalls. The input
//                   register feeds a single add-fold and byte-capture step
//                   into the state registers each cycle that it moves.
//   Result path   : the last item's transaction passes the input register,
//                   the snapshot register and the output register, in order.
//   Stall         : a non-last item in the input register never waits for the
//                   result side. A last item waits there only while the snapshot
//                   and output registers are both occupied and result_ready is low.
//   Reset         : rst_n clears all valid flags and the running state; the
//                   state also returns to zero after each last item, so the
//                   next image can follow in the very next cycle.
`include "pe_image_checksum_top_macros.svh"
module pe_image_checksum_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  pic_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output pic_pkg::out_item_t result
);
    import pic_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    logic      in_fire;
    logic      accept;
    snap_t     snap;
    fin_stat_t fin_stat;

    // input register moves on every cycle, unless a last item finds the
    // finisher full
    assign in_fire    = in_valid_reg && (!in_item_reg.last || fin_stat.snap_ready);
    assign item_ready = !in_valid_reg || in_fire;
    assign accept     = item_valid && item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (item_ready)
            in_valid_reg <= item_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= item;
    end

    pic_accum u_accum (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (in_fire),
        .item  (in_item_reg),
        .snap  (snap)
    );

    pic_finish u_finish (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (in_fire && in_item_reg.last),
        .snap         (snap),
        .result_ready (result_ready),
        .result_valid (result_valid),
        .result       (result),
        .stat         (fin_stat)
    );

    // a non-last item in the input register never blocks the input
    `PIC_ASSERT_SAME(a_nonlast_flows, clk, rst_n, in_valid_reg && !in_item_reg.last, item_ready)
    // a held snapshot is not dropped while the output side is blocked
    `PIC_ASSERT_NEXT(a_snap_held, clk, rst_n, fin_stat.snap_busy && result_valid && !result_ready, fin_stat.snap_busy)
    // a finished image with a free output reaches the result register next cycle
    `PIC_ASSERT_NEXT(a_snap_to_out, clk, rst_n, fin_stat.snap_busy && (!result_valid || result_ready), result_valid)

endmodule
